### hdl/cbce_pkg.sv
// Shared constants and decode tables for the calculator execute block.
package cbce_pkg;

   localparam int DIGITS_DEF = 16;
   localparam int BANK_ENTRIES_DEF = 8;
   localparam int STACK_DEPTH_DEF = 3;

   localparam logic [1:0] ERR_OK = 2'd0;
   localparam logic [1:0] ERR_INSTR = 2'd1;
   localparam logic [1:0] ERR_FORM = 2'd2;

   localparam logic [3:0] FMT_FLAG = 4'hC;
   localparam logic [3:0] FMT_MISC = 4'hE;
   localparam logic [3:0] FMT_BAD0 = 4'h6;
   localparam logic [3:0] FMT_BAD1 = 4'hB;

   localparam logic [12:0] MISC_NOP_WORD = 13'h0EFF;
   localparam logic [7:0] R5_SHORT = 8'h39;

   // misc group codes
   localparam logic [3:0] MC_LOAD_Y = 4'h0;
   localparam logic [3:0] MC_BANK_Q = 4'h1;
   localparam logic [3:0] MC_BR_R5 = 4'h2;
   localparam logic [3:0] MC_RET = 4'h3;
   localparam logic [3:0] MC_STORE_X = 4'h4;
   localparam logic [3:0] MC_LOAD_X = 4'h5;
   localparam logic [3:0] MC_STORE_Y = 4'h6;
   localparam logic [3:0] MC_DISP = 4'h7;
   localparam logic [3:0] MC_DEC = 4'h8;
   localparam logic [3:0] MC_HEX = 4'h9;
   localparam logic [3:0] MC_BANK_R5 = 4'hA;
   localparam logic [3:0] MC_OFF = 4'hB;
   localparam logic [3:0] MC_XMANT = 4'hC;
   localparam logic [3:0] MC_KEY = 4'hD;
   localparam logic [3:0] MC_YMANT = 4'hE;
   localparam logic [3:0] MC_NOP = 4'hF;

   // first digit of each mask
   function automatic logic [3:0] mask_first(input logic [3:0] mf);
      case (mf)
         4'h0: mask_first = 4'd12;
         4'h2, 4'h4: mask_first = 4'd2;
         4'h8, 4'hA: mask_first = 4'd14;
         4'h7: mask_first = 4'd0;
         4'h9, 4'hD: mask_first = 4'd13;
         4'hF: mask_first = 4'd15;
         default: mask_first = 4'd0;
      endcase
   endfunction

   // last digit of each mask
   function automatic logic [3:0] mask_last(input logic [3:0] mf);
      case (mf)
         4'h0, 4'h2, 4'h3: mask_last = 4'd12;
         4'h1, 4'h9, 4'hA, 4'hF: mask_last = 4'd15;
         4'h4: mask_last = 4'd2;
         4'h5: mask_last = 4'd1;
         4'h7, 4'hD: mask_last = 4'd13;
         4'h8: mask_last = 4'd14;
         default: mask_last = 4'd0;
      endcase
   endfunction

endpackage

### hdl/calculator_bcd_cpu_execute.sv
// Calculator CPU execute stage: digit-serial register file, carry chain and control.
//
// Usage: each item on the req_ channel is one instruction word with the pending
// key code; each item returned on the rsp_ channel is the machine state after it
// (next PC, COND, R5, registers A and B, display flags, halt flag, error code).
// One result per instruction, in order.
//
// Timing: an accepted item first passes a decode state, then a digit loop in
// which all 64-bit registers rotate one nibble per cycle through a 4-bit adder
// and subtractor with carry, then a done state that loads the result register.
// The next item is accepted once the result register has been loaded, so while
// a result waits to be taken the following item already runs. Once powered off,
// an item skips the digit loop and goes from decode straight to the done state.
//
// Reset clears every register, the banks, the return stack and all flags; the
// result register goes empty. If the receiver stalls, the result holds in the
// output register and a second finished item waits until it drains.
module calculator_bcd_cpu_execute #(
   parameter int DIGITS = cbce_pkg::DIGITS_DEF,
   parameter int BANK_ENTRIES = cbce_pkg::BANK_ENTRIES_DEF,
   parameter int STACK_DEPTH = cbce_pkg::STACK_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [12:0] instruction, [20:13] key_code
   input  logic [23:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [10:0] next_pc, [11] cond_out, [19:12] r5_out, [83:20] a_value,
   // [147:84] b_value, [148] display_refresh, [149] display_empty,
   // [150] halted_out, [152:151] error_code
   output logic [159:0] rsp_tdata
);
   import cbce_pkg::*;

   localparam int RW = 4 * DIGITS;
   localparam int DW = $clog2(DIGITS);
   localparam int BW = $clog2(BANK_ENTRIES);

   typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_DIGIT, ST_DONE} state_type;

   state_type state_ff;
   logic [DW-1:0] cnt_ff;
   logic [12:0] op_ff;
   logic [7:0] key_ff;

   logic [RW-1:0] a_ff, b_ff, c_ff, d_ff, xb_ff, yb_ff;
   logic [RW-1:0] xbank_mem [BANK_ENTRIES];
   logic [RW-1:0] ybank_mem [BANK_ENTRIES];
   logic [10:0] pc_ff;
   logic [10:0] stack_ff [STACK_DEPTH];
   logic cond_ff, hex_ff, short_ff, blank_ff, off_ff;
   logic [7:0] r5_ff;
   logic [2:0] bank_ff;

   // per-item serial work state
   logic cy_ff, all9_ff;
   logic [3:0] prev_ff;
   logic [7:0] r5n_ff;
   logic [1:0] err_ff;
   logic refresh_ff;

   logic out_valid_ff;
   logic [159:0] out_ff;

   // decoded fields
   logic [3:0] mf, f0, f1, p, q;
   logic [1:0] j, l;
   logic [2:0] k;
   logic n, two, do_mask, do_flag, do_misc, bad_form;
   logic [3:0] cur, lo_r5, hi_r5;

   always_comb begin
      mf = op_ff[11:8];
      f0 = mask_first(mf);
      f1 = mask_last(mf);
      j = op_ff[7:6];
      k = op_ff[5:3];
      l = op_ff[2:1];
      n = op_ff[0];
      p = op_ff[3:0];
      q = op_ff[7:4];
      two = (f0 < 4'd15) && (f0 < f1);
      do_flag = !op_ff[12] && mf == FMT_FLAG;
      do_misc = !op_ff[12] && mf == FMT_MISC;
      do_mask = !op_ff[12] && !do_flag && !do_misc && mf != FMT_BAD0 && mf != FMT_BAD1;
      bad_form = (l == 2'd3 && !n && !(j == 2'd0 && !k[2])) ||
                 (l == 2'd1 && k[2]) || (l == 2'd2 && k > 3'd5);
      cur = cnt_ff;
   end

   // select a register by code
   function automatic logic [3:0] pick_low(input logic [1:0] s, input logic [RW-1:0] ra,
                                           input logic [RW-1:0] rb, input logic [RW-1:0] rc,
                                           input logic [RW-1:0] rd);
      case (s)
         2'd0: pick_low = ra[3:0];
         2'd1: pick_low = rb[3:0];
         2'd2: pick_low = rc[3:0];
         default: pick_low = rd[3:0];
      endcase
   endfunction

   // next digit of register j (digit i+1 sits in bits [7:4] during rotation)
   function automatic logic [3:0] d_next_j(input logic [1:0] s);
      case (s)
         2'd0: d_next_j = a_ff[7:4];
         2'd1: d_next_j = b_ff[7:4];
         2'd2: d_next_j = c_ff[7:4];
         default: d_next_j = d_ff[7:4];
      endcase
   endfunction

   // digit-serial datapath signals
   logic [3:0] ja, ka, tdig, rdig, newj, newk, newa, newb, newc, newd, newx, newy;
   logic in_mask, base16, cy_next;
   logic [4:0] sum;
   logic [5:0] diff;
   logic wj, wk;
   logic [3:0] fbit, fval;

   always_comb begin
      ja = pick_low(j, a_ff, b_ff, c_ff, d_ff);
      ka = pick_low(k[1:0], a_ff, b_ff, c_ff, d_ff);
      in_mask = cur >= f0 && cur <= f1;
      base16 = hex_ff || mf[3];
      lo_r5 = r5_ff[3:0];
      hi_r5 = r5_ff[7:4];
      // operand digit t[i]
      tdig = 4'd0;
      if (in_mask) begin
         if (!k[2]) tdig = ka;
         else if (k == 3'd4 && cur == f0) tdig = 4'd1;
         else if (k == 3'd6 && cur == f0) tdig = lo_r5;
         else if (k == 3'd7 && cur == f0) tdig = lo_r5;
         else if (k == 3'd7 && two && cur == f0 + 4'd1) tdig = hi_r5;
      end
      // arithmetic / shift digit r[i]
      sum = {1'b0, ja} + {1'b0, tdig} + {4'd0, cy_ff};
      diff = {2'b0, ja} - {2'b0, tdig} - {5'd0, cy_ff};
      rdig = ja;
      cy_next = cy_ff;
      if (k != 3'd5) begin
         if (!n) begin
            if (sum >= (base16 ? 5'd16 : 5'd10)) begin
               rdig = 4'(sum - (base16 ? 5'd16 : 5'd10));
               cy_next = 1'b1;
            end else begin
               rdig = sum[3:0];
               cy_next = 1'b0;
            end
         end else begin
            // 8-bit wrap in the model equals negative test here
            if (diff[5] || (!base16 && diff[3:0] >= 4'd10)) begin
               rdig = 4'(diff + (base16 ? 6'd16 : 6'd10));
               cy_next = 1'b1;
            end else begin
               rdig = diff[3:0];
               cy_next = 1'b0;
            end
         end
      end else if (!n) begin
         rdig = (cur == f0) ? 4'd0 : prev_ff;
      end else begin
         rdig = (cur == f1) ? 4'd0 : d_next_j(j);
      end
      fbit = 4'd1 << op_ff[3:2];
      case (op_ff[1:0])
         2'd0: fval = ja | fbit;
         2'd1: fval = ja & ~fbit;
         2'd3: fval = ja ^ fbit;
         default: fval = ja;
      endcase
      // write-back decisions
      wj = 1'b0;
      wk = 1'b0;
      newj = ja;
      newk = ka;
      if (do_mask && !bad_form && in_mask) begin
         if (l == 2'd3) begin
            if (!n) begin
               newj = ka;
               newk = ja;
               wj = 1'b1;
               wk = 1'b1;
            end else if (k != 3'd5) begin
               newj = tdig;
               wj = 1'b1;
            end
         end else if (l == 2'd0 || (l == 2'd2 && k == 3'd5)) begin
            newj = rdig;
            wj = 1'b1;
         end else if (l == 2'd1) begin
            newk = rdig;
            wk = 1'b1;
         end
      end
      if (do_flag && op_ff[5:4] != 2'd0 && cur == {2'b11, op_ff[5:4]}) begin
         newj = fval;
         wj = 1'b1;
      end
      newa = a_ff[3:0];
      newb = b_ff[3:0];
      newc = c_ff[3:0];
      newd = d_ff[3:0];
      if (wk) begin
         case (k[1:0])
            2'd0: newa = newk;
            2'd1: newb = newk;
            2'd2: newc = newk;
            default: newd = newk;
         endcase
      end
      if (wj) begin
         case (j)
            2'd0: newa = newj;
            2'd1: newb = newj;
            2'd2: newc = newj;
            default: newd = newj;
         endcase
      end
      newx = xb_ff[3:0];
      newy = yb_ff[3:0];
      if (do_misc && !off_ff) begin
         if (p == MC_STORE_X || (p == MC_XMANT && (!short_ff || cur <= 4'd12)))
            newx = a_ff[3:0];
         if (p == MC_STORE_Y || (p == MC_YMANT && (!short_ff || cur <= 4'd12)))
            newy = a_ff[3:0];
         if (p == MC_LOAD_Y) newa = yb_ff[3:0];
         if (p == MC_LOAD_X) newa = xb_ff[3:0];
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_ff;

   logic [10:0] pc_inc;
   logic run;
   assign pc_inc = pc_ff + 11'd1;
   assign run = !off_ff;

   // sequencer, registers and banks
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         a_ff <= '0;
         b_ff <= '0;
         c_ff <= '0;
         d_ff <= '0;
         for (int e = 0; e < BANK_ENTRIES; e++) begin
            xbank_mem[e] <= '0;
            ybank_mem[e] <= '0;
         end
         for (int e = 0; e < STACK_DEPTH; e++) stack_ff[e] <= '0;
         pc_ff <= '0;
         cond_ff <= 1'b0;
         hex_ff <= 1'b0;
         short_ff <= 1'b0;
         blank_ff <= 1'b0;
         off_ff <= 1'b0;
         r5_ff <= '0;
         bank_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready && state_ff != ST_DONE) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  op_ff <= req_tdata[12:0];
                  key_ff <= req_tdata[20:13];
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               xb_ff <= xbank_mem[bank_ff[BW-1:0]];
               yb_ff <= ybank_mem[bank_ff[BW-1:0]];
               cy_ff <= 1'b0;
               all9_ff <= 1'b1;
               prev_ff <= '0;
               r5n_ff <= '0;
               refresh_ff <= 1'b0;
               err_ff <= ERR_OK;
               if (run) begin
                  if (!op_ff[12] && (mf == FMT_BAD0 || mf == FMT_BAD1))
                     err_ff <= ERR_INSTR;
                  else if (do_flag && op_ff[5:4] == 2'd0) err_ff <= ERR_FORM;
                  else if (do_mask && bad_form) err_ff <= ERR_FORM;
                  else if (do_misc && p == MC_NOP && op_ff != MISC_NOP_WORD)
                     err_ff <= ERR_INSTR;
               end
               cnt_ff <= '0;
               state_ff <= run ? ST_DIGIT : ST_DONE;
            end
            ST_DIGIT: begin
               // rotate every register one digit right, new digit into the top
               a_ff <= {newa, a_ff[RW-1:4]};
               b_ff <= {newb, b_ff[RW-1:4]};
               c_ff <= {newc, c_ff[RW-1:4]};
               d_ff <= {newd, d_ff[RW-1:4]};
               xb_ff <= {newx, xb_ff[RW-1:4]};
               yb_ff <= {newy, yb_ff[RW-1:4]};
               prev_ff <= ja;
               if (cur < 4'd12 && b_ff[3:0] != 4'd9) all9_ff <= 1'b0;
               // carry only for arithmetic forms, not for exchange or store
               if (do_mask && in_mask && k != 3'd5 && l != 2'd3) cy_ff <= cy_next;
               // capture R5 candidate digits
               if (do_mask && cur == f0)
                  r5n_ff[3:0] <= (l == 2'd3) ? tdig : rdig;
               if (do_mask && two && cur == f0 + 4'd1)
                  r5n_ff[7:4] <= (l == 2'd3) ? tdig : rdig;
               if (do_flag && op_ff[1:0] == 2'd2 && op_ff[5:4] != 2'd0 &&
                   cur == {2'b11, op_ff[5:4]} && (ja & fbit) != 4'd0)
                  cond_ff <= 1'b1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DW'(DIGITS - 1)) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!out_valid_ff || rsp_tready) begin
                  logic [10:0] npc;
                  logic ncond, nblank, nrefresh, noff, nhex, nshort;
                  logic [7:0] nr5;
                  logic [2:0] nbank;
                  npc = pc_ff;
                  ncond = cond_ff;
                  nr5 = r5_ff;
                  nblank = blank_ff;
                  nrefresh = 1'b0;
                  noff = off_ff;
                  nhex = hex_ff;
                  nshort = short_ff;
                  nbank = bank_ff;
                  if (run) begin
                     npc = pc_inc;
                     if (op_ff[12]) begin
                        ncond = 1'b0;
                        if (op_ff[11]) begin
                           if (cond_ff == op_ff[10]) npc = {pc_inc[10], op_ff[9:0]};
                        end else begin
                           for (int e = STACK_DEPTH - 1; e > 0; e--)
                              stack_ff[e] <= stack_ff[e-1];
                           stack_ff[0] <= pc_inc;
                           npc = op_ff[10:0];
                        end
                     end else if (do_mask && err_ff == ERR_OK) begin
                        nr5 = two ? r5n_ff : {4'd0, r5n_ff[3:0]};
                        if (cy_ff) ncond = 1'b1;
                     end else if (do_misc && err_ff == ERR_OK) begin
                        case (p)
                           MC_BANK_Q: nbank = q[2:0];
                           MC_BR_R5: begin
                              nshort = r5_ff == R5_SHORT;
                              npc = {3'd0, r5_ff};
                           end
                           MC_RET: begin
                              ncond = 1'b0;
                              npc = stack_ff[0];
                              for (int e = 0; e < STACK_DEPTH - 1; e++)
                                 stack_ff[e] <= stack_ff[e+1];
                              stack_ff[STACK_DEPTH-1] <= '0;
                           end
                           MC_DISP: begin
                              if (!all9_ff || !blank_ff) begin
                                 nblank = all9_ff;
                                 nrefresh = 1'b1;
                              end
                           end
                           MC_DEC: nhex = 1'b0;
                           MC_HEX: nhex = 1'b1;
                           MC_BANK_R5: nbank = r5_ff[2:0];
                           MC_OFF: noff = 1'b1;
                           MC_KEY: begin
                              if (key_ff != 8'd0) begin
                                 ncond = 1'b1;
                                 nr5 = key_ff;
                              end
                           end
                           default: ;
                        endcase
                        xbank_mem[bank_ff[BW-1:0]] <= xb_ff;
                        ybank_mem[bank_ff[BW-1:0]] <= yb_ff;
                     end
                  end
                  pc_ff <= npc;
                  cond_ff <= ncond;
                  r5_ff <= nr5;
                  blank_ff <= nblank;
                  off_ff <= noff;
                  hex_ff <= nhex;
                  short_ff <= nshort;
                  bank_ff <= nbank;
                  out_ff <= {7'd0, err_ff, noff, nblank, nrefresh, b_ff, a_ff, nr5, ncond, npc};
                  out_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### bench/calculator_bcd_cpu_execute_checker.sv
// Checker for the calculator execute block: predicts each result and compares it.
`timescale 1ns / 100ps
module calculator_bcd_cpu_execute_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [23:0] req_tdata,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [159:0] rsp_tdata,
   output int fail_count,
   output int pending_count
);
   import cbce_pkg::*;

   typedef struct packed {
      logic [1:0] err;
      logic halted;
      logic blank;
      logic refresh;
      logic [63:0] b;
      logic [63:0] a;
      logic [7:0] r5;
      logic cond;
      logic [10:0] pc;
   } machine_state_type;

   // architectural copy of the machine
   logic [63:0] m_a, m_b, m_c, m_d;
   logic [63:0] m_x [8];
   logic [63:0] m_y [8];
   logic [10:0] m_pc;
   logic [10:0] m_stack [3];
   logic m_cond, m_hex, m_short, m_blank, m_off;
   logic [7:0] m_r5;
   logic [2:0] m_bank;

   machine_state_type expected_states [$];

   function automatic logic [3:0] first_digit(input logic [3:0] mf);
      case (mf)
         4'h0: return 4'd12;
         4'h2, 4'h4: return 4'd2;
         4'h8, 4'hA: return 4'd14;
         4'h9, 4'hD: return 4'd13;
         4'hF: return 4'd15;
         default: return 4'd0;
      endcase
   endfunction

   function automatic logic [3:0] last_digit(input logic [3:0] mf);
      case (mf)
         4'h0, 4'h2, 4'h3: return 4'd12;
         4'h1, 4'h9, 4'hA, 4'hF: return 4'd15;
         4'h4: return 4'd2;
         4'h5: return 4'd1;
         4'h7, 4'hD: return 4'd13;
         4'h8: return 4'd14;
         default: return 4'd0;
      endcase
   endfunction

   function automatic logic [63:0] get_reg(input logic [1:0] s);
      case (s)
         2'd0: return m_a;
         2'd1: return m_b;
         2'd2: return m_c;
         default: return m_d;
      endcase
   endfunction

   function automatic void set_reg(input logic [1:0] s, input logic [63:0] v);
      case (s)
         2'd0: m_a = v;
         2'd1: m_b = v;
         2'd2: m_c = v;
         default: m_d = v;
      endcase
   endfunction

   task automatic clear_machine();
      m_a = '0; m_b = '0; m_c = '0; m_d = '0;
      for (int i = 0; i < 8; i++) begin
         m_x[i] = '0;
         m_y[i] = '0;
      end
      for (int i = 0; i < 3; i++) m_stack[i] = '0;
      m_pc = '0; m_cond = 0; m_r5 = '0; m_hex = 0; m_bank = '0;
      m_short = 0; m_blank = 0; m_off = 0;
   endtask

   function automatic logic [1:0] flag_instr(input logic [12:0] op);
      logic [63:0] v;
      logic [3:0] d, nib, bitm;
      v = get_reg(op[7:6]);
      if (op[5:4] == 2'd0) return ERR_FORM;
      d = {2'b11, op[5:4]};
      nib = v[d*4 +: 4];
      bitm = 4'd1 << op[3:2];
      case (op[1:0])
         2'd0: v[d*4 +: 4] = nib | bitm;
         2'd1: v[d*4 +: 4] = nib & ~bitm;
         2'd2: if ((nib & bitm) != 0) m_cond = 1;
         default: v[d*4 +: 4] = nib ^ bitm;
      endcase
      set_reg(op[7:6], v);
      return ERR_OK;
   endfunction

   function automatic logic [1:0] digit_instr(input logic [12:0] op);
      int f0, f1, base, cy, x;
      logic [1:0] j, l;
      logic [2:0] k;
      logic n, two;
      logic [3:0] mf;
      logic [3:0] t [16];
      logic [3:0] r [16];
      logic [63:0] jv, kv, av;
      mf = op[11:8];
      f0 = first_digit(mf);
      f1 = last_digit(mf);
      j = op[7:6]; k = op[5:3]; l = op[2:1]; n = op[0];
      two = (f0 < 15) && (f0 < f1);
      if (l == 2'd3 && !n && !(j == 2'd0 && k < 4)) return ERR_FORM;
      if (l == 2'd1 && k >= 4) return ERR_FORM;
      if (l == 2'd2 && k > 5) return ERR_FORM;
      for (int i = 0; i < 16; i++) begin
         t[i] = '0;
         r[i] = '0;
      end
      kv = (k < 4) ? get_reg(k[1:0]) : '0;
      if (k < 4) begin
         for (int i = f0; i <= f1; i++) t[i] = kv[i*4 +: 4];
      end else if (k == 4) t[f0] = 4'd1;
      else if (k == 6) t[f0] = m_r5[3:0];
      else if (k == 7) begin
         t[f0] = m_r5[3:0];
         if (two) t[f0+1] = m_r5[7:4];
      end
      if (l == 2'd3) begin
         if (!n) begin
            av = m_a;
            for (int i = f0; i <= f1; i++) begin
               m_a[i*4 +: 4] = kv[i*4 +: 4];
               kv[i*4 +: 4] = av[i*4 +: 4];
            end
            // A against A leaves A's digits in place
            if (k[1:0] != 2'd0) set_reg(k[1:0], kv);
         end else if (k != 5) begin
            jv = get_reg(j);
            for (int i = f0; i <= f1; i++) jv[i*4 +: 4] = t[i];
            set_reg(j, jv);
         end
         m_r5 = {two ? t[f0+1] : 4'd0, t[f0]};
         return ERR_OK;
      end
      jv = get_reg(j);
      for (int i = f0; i <= f1; i++) r[i] = jv[i*4 +: 4];
      if (k != 5) begin
         base = (m_hex || mf >= 8) ? 16 : 10;
         cy = 0;
         for (int i = f0; i <= f1; i++) begin
            if (!n) begin
               x = r[i] + t[i] + cy;
               if (x >= base) begin x -= base; cy = 1; end else cy = 0;
            end else begin
               x = (r[i] - t[i] - cy) & 8'hFF;
               if (x >= base) begin x = (x + base) & 8'hFF; cy = 1; end else cy = 0;
            end
            r[i] = x[3:0];
         end
         if (cy != 0) m_cond = 1;
      end else if (!n) begin
         for (int i = f1; i > f0; i--) r[i] = r[i-1];
         r[f0] = '0;
      end else begin
         for (int i = f0; i < f1; i++) r[i] = r[i+1];
         r[f1] = '0;
      end
      m_r5 = {two ? r[f0+1] : 4'd0, r[f0]};
      if (l == 2'd0 || (l == 2'd2 && k == 5)) begin
         jv = get_reg(j);
         for (int i = f0; i <= f1; i++) jv[i*4 +: 4] = r[i];
         set_reg(j, jv);
      end else if (l == 2'd1) begin
         kv = get_reg(k[1:0]);
         for (int i = f0; i <= f1; i++) kv[i*4 +: 4] = r[i];
         set_reg(k[1:0], kv);
      end
      return ERR_OK;
   endfunction

   function automatic logic [1:0] misc_instr(input logic [12:0] op, input logic [7:0] key,
                                             inout logic refresh);
      logic [3:0] q;
      int last;
      logic all9;
      q = op[7:4];
      last = m_short ? 12 : 15;
      case (op[3:0])
         MC_LOAD_Y: m_a = m_y[m_bank];
         MC_BANK_Q: m_bank = q[2:0];
         MC_BR_R5: begin
            m_short = (m_r5 == R5_SHORT);
            m_pc = {3'b000, m_r5};
         end
         MC_RET: begin
            m_cond = 0;
            m_pc = m_stack[0];
            m_stack[0] = m_stack[1];
            m_stack[1] = m_stack[2];
            m_stack[2] = '0;
         end
         MC_STORE_X: m_x[m_bank] = m_a;
         MC_LOAD_X: m_a = m_x[m_bank];
         MC_STORE_Y: m_y[m_bank] = m_a;
         MC_DISP: begin
            all9 = 1;
            for (int i = 0; i < 12; i++) if (m_b[i*4 +: 4] != 4'd9) all9 = 0;
            if (!all9 || !m_blank) begin
               m_blank = all9;
               refresh = 1;
            end
         end
         MC_DEC: m_hex = 0;
         MC_HEX: m_hex = 1;
         MC_BANK_R5: m_bank = m_r5[2:0];
         MC_OFF: m_off = 1;
         MC_XMANT: for (int i = 0; i <= last; i++) m_x[m_bank][i*4 +: 4] = m_a[i*4 +: 4];
         MC_KEY: if (key != 0) begin m_cond = 1; m_r5 = key; end
         MC_YMANT: for (int i = 0; i <= last; i++) m_y[m_bank][i*4 +: 4] = m_a[i*4 +: 4];
         default: if (q != 4'hF) return ERR_INSTR;
      endcase
      return ERR_OK;
   endfunction

   // run one instruction and return the state it leaves
   function automatic machine_state_type execute_instr(input logic [12:0] op,
                                                       input logic [7:0] key);
      machine_state_type s;
      logic refresh;
      logic [1:0] err;
      logic [3:0] mf;
      refresh = 0;
      err = ERR_OK;
      mf = op[11:8];
      if (!m_off) begin
         m_pc = m_pc + 11'd1;
         if (op[12]) begin
            if (op[11]) begin
               if (m_cond == op[10]) m_pc = {m_pc[10], op[9:0]};
               m_cond = 0;
            end else begin
               m_stack[2] = m_stack[1];
               m_stack[1] = m_stack[0];
               m_stack[0] = m_pc;
               m_cond = 0;
               m_pc = op[10:0];
            end
         end else if (mf == FMT_FLAG) err = flag_instr(op);
         else if (mf == FMT_MISC) err = misc_instr(op, key, refresh);
         else if (mf == FMT_BAD0 || mf == FMT_BAD1) err = ERR_INSTR;
         else err = digit_instr(op);
      end
      s.pc = m_pc; s.cond = m_cond; s.r5 = m_r5; s.a = m_a; s.b = m_b;
      s.refresh = refresh; s.blank = m_blank; s.halted = m_off; s.err = err;
      return s;
   endfunction

   machine_state_type got, want;

   always @(posedge clock) begin
      if (reset) begin
         clear_machine();
         expected_states.delete();
         fail_count <= 0;
      end else begin
         // predict on each accepted instruction
         if (req_tvalid && req_tready)
            expected_states.push_back(execute_instr(req_tdata[12:0], req_tdata[20:13]));
         // compare each accepted result
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[152:0];
            if (expected_states.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_states.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("mismatch: exp pc=%h c=%b r5=%h a=%h b=%h rf=%b bl=%b h=%b e=%0d",
                        want.pc, want.cond, want.r5, want.a, want.b, want.refresh,
                        want.blank, want.halted, want.err);
                     $display("          got pc=%h c=%b r5=%h a=%h b=%h rf=%b bl=%b h=%b e=%0d",
                        got.pc, got.cond, got.r5, got.a, got.b, got.refresh,
                        got.blank, got.halted, got.err);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= expected_states.size();
   end
endmodule

### bench/calculator_bcd_cpu_execute_tb.sv
// Top of the calculator execute testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module calculator_bcd_cpu_execute_tb;
   import cbce_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [159:0] rsp_tdata;
   int fail_count, pending_count;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   logic hold_receiver = 0;
   int idle_cycles = 0;

   always #10 clock = ~clock;

   calculator_bcd_cpu_execute dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   calculator_bcd_cpu_execute_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // receiver: random stalls, or a long hold when asked
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= !hold_receiver && ($urandom_range(99) >= receiver_stall_pct);
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // offer one instruction, with an optional random gap first
   task automatic send_instr(input logic [12:0] op, input logic [7:0] key);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {3'b000, key, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // mostly well-formed instructions spread over all groups
   function automatic logic [12:0] random_instr();
      logic [12:0] op;
      int pick;
      op = 13'($urandom);
      pick = $urandom_range(99);
      if (pick < 50) begin
         op[12] = 0;
         if (op[11:8] == FMT_BAD0 || op[11:8] == FMT_BAD1 || op[11:8] == FMT_MISC)
            op[11:8] = 4'h7;
      end else if (pick < 65) begin
         op[12:8] = {1'b0, FMT_FLAG};
      end else if (pick < 82) begin
         op[12:8] = {1'b0, FMT_MISC};
         // keep power off for the end; it makes everything after it idle
         if (op[3:0] == MC_OFF) op[3:0] = MC_HEX;
      end else if (pick < 94) begin
         op[12] = 1;
      end
      return op;
   endfunction

   function automatic logic [7:0] random_key();
      return ($urandom_range(1) != 0) ? 8'($urandom) : 8'd0;
   endfunction

   logic [12:0] directed_ops [$];
   int phase_items;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every group and its corner cases
      directed_ops = '{13'h0E09, 13'h0700, 13'h07FF, 13'h0701, 13'h0F3E, 13'h0F3F,
                       13'h0C30, 13'h0C72, 13'h0CF3, 13'h0C01, 13'h0D0D, 13'h0758,
                       13'h07F4, 13'h076E, 13'h0600, 13'h0BFF, 13'h0EFF, 13'h0E0F,
                       13'h0E07, 13'h0E0D, 13'h0E0A, 13'h0E14, 13'h0E03, 13'h1FFF,
                       13'h1ABC, 13'h0E08, 13'h0E02};
      foreach (directed_ops[i]) send_instr(directed_ops[i], (i % 2) ? 8'hFF : 8'h00);
      drain();

      // random phases with differing idle patterns
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            1: begin sender_idle_pct = 74; receiver_stall_pct = 0; end
            2: begin sender_idle_pct = 0; receiver_stall_pct = 74; end
            3: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
            default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
         endcase
         if (ph == 4) begin
            // hold the receiver off while items keep coming
            fork
               begin
                  hold_receiver = 1;
                  repeat (300) @(posedge clock);
                  hold_receiver = 0;
               end
            join_none
         end
         phase_items = 240;
         for (int i = 0; i < phase_items; i++) send_instr(random_instr(), random_key());
         // pause until every result has arrived
         drain();
      end
      // a final power off and an ignored word after it
      send_instr({1'b0, FMT_MISC, 4'h0, MC_OFF}, 8'h00);
      send_instr(13'h0701, 8'h12);
      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

### calculator_bcd_cpu_execute.f
hdl/cbce_pkg.sv
hdl/calculator_bcd_cpu_execute.sv
bench/calculator_bcd_cpu_execute_checker.sv
bench/calculator_bcd_cpu_execute_tb.sv
